// ===== src/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

	// Event kinds on the result channel.
	localparam logic [1:0] EV_ROW_BEGIN = 2'd0;
	localparam logic [1:0] EV_DATA      = 2'd1;
	localparam logic [1:0] EV_FIELD_END = 2'd2;
	localparam logic [1:0] EV_ROW_END   = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_QUOTE     = 2'd0;
	localparam logic [1:0] REG_SEPARATOR = 2'd1;
	localparam logic [1:0] REG_EOL       = 2'd2;

	// Reset values of the character registers.
	localparam logic [7:0] QUOTE_RESET     = 8'd34;
	localparam logic [7:0] SEPARATOR_RESET = 8'd59;
	localparam logic [7:0] EOL_RESET       = 8'd10;

	localparam int ROW_OUT_BITS = 32;
	localparam int COL_OUT_BITS = 16;

	// One queue entry: the events caused by one input item. When both flags
	// are set, the row begin comes first and both events share row and column.
	typedef struct packed {
		logic                    has_begin;
		logic                    has_main;
		logic [1:0]              kind;
		logic [7:0]              data;
		logic [ROW_OUT_BITS-1:0] row;
		logic [COL_OUT_BITS-1:0] col;
	} csvt_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} csvt_qstat_t;

endpackage

// ===== src/csvt_front.sv =====
// ----------------------------------------------------------------------------
// csvt_front
// Byte classifier: scan state, row and column counters, character registers.
// ----------------------------------------------------------------------------
module csvt_front #(
	parameter int ROW_BITS    = 32,
	parameter int COLUMN_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	input  logic [7:0]           text_byte,
	input  csvt_pkg::csvt_qstat_t qstat,
	output logic                 push,
	output csvt_pkg::csvt_rec_t  push_rec
);
	import csvt_pkg::*;

	localparam logic [2:0] ST_LINE        = 3'd0;
	localparam logic [2:0] ST_FIELD_START = 3'd1;
	localparam logic [2:0] ST_PLAIN       = 3'd2;
	localparam logic [2:0] ST_QUOTED      = 3'd3;
	localparam logic [2:0] ST_QUOTE_SEEN  = 3'd4;
	localparam logic [2:0] ST_SKIP        = 3'd5;

	logic [7:0]             quote_q, sep_q, eol_q;
	logic [2:0]             state_q, state_d, s1, s2;
	logic [ROW_BITS-1:0]    row_q, row_d;
	logic [COLUMN_BITS-1:0] col_q, col_d, col_eff;
	logic                   is_begin, consumed, has_main, accept;
	logic [1:0]             kind;
	logic [7:0]             data;
	logic [ROW_BITS+ROW_OUT_BITS-1:0]    row_ext;
	logic [COLUMN_BITS+COL_OUT_BITS-1:0] col_ext;
	logic                   row_inc, col_inc;

	assign accept = in_valid & ~qstat.full;

	always_comb begin
		is_begin = (state_q == ST_LINE) || (state_q > ST_SKIP);
		s1       = is_begin ? ST_FIELD_START : state_q;
		col_eff  = is_begin ? '0 : col_q;
		consumed = 1'b0;
		s2       = s1;
		if (s1 == ST_FIELD_START) begin
			if (text_byte == quote_q) begin
				s2       = ST_QUOTED;
				consumed = 1'b1;
			end else begin
				s2 = ST_PLAIN;
			end
		end
		state_d  = s2;
		has_main = 1'b0;
		kind     = EV_DATA;
		data     = 8'd0;
		row_inc  = 1'b0;
		col_inc  = 1'b0;
		if (!consumed) begin
			unique case (s2)
				ST_PLAIN: begin
					priority if (text_byte == sep_q) begin
						has_main = 1'b1;
						kind     = EV_FIELD_END;
						col_inc  = 1'b1;
						state_d  = ST_FIELD_START;
					end else if (text_byte == eol_q) begin
						has_main = 1'b1;
						kind     = EV_ROW_END;
						row_inc  = 1'b1;
						state_d  = ST_LINE;
					end else begin
						has_main = 1'b1;
						data     = text_byte;
					end
				end
				ST_QUOTED: begin
					if (text_byte == quote_q) begin
						state_d = ST_QUOTE_SEEN;
					end else begin
						has_main = 1'b1;
						data     = text_byte;
					end
				end
				ST_QUOTE_SEEN: begin
					priority if (text_byte == quote_q) begin
						has_main = 1'b1;
						data     = quote_q;
						state_d  = ST_QUOTED;
					end else if (text_byte == sep_q) begin
						has_main = 1'b1;
						kind     = EV_FIELD_END;
						col_inc  = 1'b1;
						state_d  = ST_FIELD_START;
					end else if (text_byte == eol_q) begin
						has_main = 1'b1;
						kind     = EV_ROW_END;
						row_inc  = 1'b1;
						state_d  = ST_LINE;
					end else begin
						state_d = ST_SKIP;
					end
				end
				ST_SKIP: begin
					// A corrupt field ends without events; its column is reused.
					priority if (text_byte == sep_q) begin
						state_d = ST_FIELD_START;
					end else if (text_byte == eol_q) begin
						row_inc = 1'b1;
						state_d = ST_LINE;
					end else begin
						state_d = ST_SKIP;
					end
				end
				default: begin
					state_d = s2;
				end
			endcase
		end
		row_d = (row_inc && row_q != '1) ? row_q + 1'b1 : row_q;
		col_d = (col_inc && col_eff != '1) ? col_eff + 1'b1 : col_eff;
	end

	// Reported indices saturate at the port widths.
	assign row_ext = {{ROW_OUT_BITS{1'b0}}, row_q};
	assign col_ext = {{COL_OUT_BITS{1'b0}}, col_eff};

	always_comb begin
		push_rec.has_begin = is_begin;
		push_rec.has_main  = has_main;
		push_rec.kind      = kind;
		push_rec.data      = data;
		push_rec.row       = (|row_ext[ROW_BITS+ROW_OUT_BITS-1:ROW_OUT_BITS]) ?
			{ROW_OUT_BITS{1'b1}} : row_ext[ROW_OUT_BITS-1:0];
		push_rec.col       = (|col_ext[COLUMN_BITS+COL_OUT_BITS-1:COL_OUT_BITS]) ?
			{COL_OUT_BITS{1'b1}} : col_ext[COL_OUT_BITS-1:0];
	end

	assign push = accept & (is_begin | has_main);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LINE;
			row_q   <= '0;
			col_q   <= '0;
		end else if (accept) begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= QUOTE_RESET;
			sep_q   <= SEPARATOR_RESET;
			eol_q   <= EOL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_QUOTE:     quote_q <= cfg_data;
				REG_SEPARATOR: sep_q   <= cfg_data;
				REG_EOL:       eol_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/csvt_queue.sv =====
// ----------------------------------------------------------------------------
// csvt_queue
// Small register queue of event records between front and back.
// ----------------------------------------------------------------------------
module csvt_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  csvt_pkg::csvt_rec_t   push_rec,
	input  logic                  pop,
	output csvt_pkg::csvt_rec_t   head_rec,
	output csvt_pkg::csvt_qstat_t qstat
);
	import csvt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	csvt_rec_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push & ~qstat.full;
	assign do_pop      = pop & ~qstat.empty;
	assign head_rec    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/csvt_back.sv =====
// ----------------------------------------------------------------------------
// csvt_back
// Expands queue records into single events and holds the output register.
// ----------------------------------------------------------------------------
module csvt_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csvt_pkg::csvt_rec_t   head_rec,
	input  csvt_pkg::csvt_qstat_t qstat,
	output logic                  pop,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [1:0]            event_kind,
	output logic [7:0]            field_byte,
	output logic [31:0]           row_index,
	output logic [15:0]           column_index,
	output logic                  last_of_run
);
	import csvt_pkg::*;

	logic       valid_q, phase_q, load, emit_begin;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic [31:0] row_q;
	logic [15:0] col_q;
	logic       last_q;

	// The output register may take a new event when empty or being drained.
	assign load       = (~valid_q | ~out_stall) & ~qstat.empty;
	assign emit_begin = head_rec.has_begin & ~phase_q;
	assign pop        = load & ~(emit_begin & head_rec.has_main);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= ~qstat.empty;
			if (load) begin
				phase_q <= emit_begin & head_rec.has_main;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= head_rec.row;
			if (emit_begin) begin
				kind_q <= EV_ROW_BEGIN;
				data_q <= 8'd0;
				col_q  <= '0;
				last_q <= ~head_rec.has_main;
			end else begin
				kind_q <= head_rec.kind;
				data_q <= head_rec.data;
				col_q  <= head_rec.col;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid    = valid_q;
	assign event_kind   = kind_q;
	assign field_byte   = data_q;
	assign row_index    = row_q;
	assign column_index = col_q;
	assign last_of_run  = last_q;

endmodule

// ===== src/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV tokenizer with configurable quote, separator and end-of-line.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     text_byte
//   result    out        out_valid / out_stall   event_kind, field_byte,
//                                                row_index, column_index,
//                                                last_of_run
//   config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One text byte is accepted per cycle while the record queue is not full;
// each causes zero, one or two result items, and the result register emits
// one item per cycle while out_stall is low. A byte's record is written into
// the queue at the edge that accepts it, and its first result item then
// moves from the queue into the output register. Reset clears the scan state,
// counters, queue and output register and restores the default characters.
// The input stalls only when the record queue is full; cfg_ready is always
// high.
//
// The front classifies each byte against the three character registers,
// advances the scan state and the saturating row and column counters, and
// writes one record of any events it caused into a short queue. The back
// expands each record into its row begin and main events and drives the
// result register, which holds a valid item still while out_stall is high.
module csv_field_tokenizer #(
	parameter int ROW_BITS    = 32,
	parameter int COLUMN_BITS = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [7:0]  field_byte,
	output logic [31:0] row_index,
	output logic [15:0] column_index,
	output logic        last_of_run
);
	import csvt_pkg::*;

	csvt_rec_t   push_rec, head_rec;
	csvt_qstat_t qstat;
	logic        push, pop;

	// Registers are written whenever offered; software writes only while idle, but the block does not enforce it.
	assign cfg_ready = 1'b1;
	assign in_stall  = qstat.full;

	csvt_front #(
		.ROW_BITS    (ROW_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.text_byte (text_byte),
		.qstat     (qstat),
		.push      (push),
		.push_rec  (push_rec)
	);

	csvt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.qstat    (qstat)
	);

	csvt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_rec     (head_rec),
		.qstat        (qstat),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.event_kind   (event_kind),
		.field_byte   (field_byte),
		.row_index    (row_index),
		.column_index (column_index),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== src/csvt_checker.sv =====
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks of the CSV field tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module csvt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  event_kind,
	input logic [7:0]  field_byte,
	input logic [31:0] row_index,
	input logic [15:0] column_index,
	input logic        last_of_run
);
	import csvt_pkg::*;

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
		$stable({event_kind, field_byte, row_index, column_index, last_of_run}))
		else $error("stalled result changed");

	// A row begin always reports column zero.
	a_begin_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_ROW_BEGIN |-> column_index == '0)
		else $error("row begin with nonzero column");

	// Only data events carry a byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_DATA |-> field_byte == 8'd0)
		else $error("non-data item carries a byte");

	// A row begin that is not last is followed at once by its partner event.
	a_partner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && event_kind == EV_ROW_BEGIN && !last_of_run
		|=> out_valid && event_kind != EV_ROW_BEGIN &&
		row_index == $past(row_index) && column_index == '0)
		else $error("row begin partner missing");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.event_kind   (event_kind),
	.field_byte   (field_byte),
	.row_index    (row_index),
	.column_index (column_index),
	.last_of_run  (last_of_run)
);
